// ----- sv/rsort_pkg.sv -----
// ----------------------------------------------------------------------------
// rsort_pkg
// Shared types and constants for the record insertion sorter.
// ----------------------------------------------------------------------------
package rsort_pkg;

  // Number of records one batch can hold.
  localparam int CAPACITY = 32;
  // Number of key bits that take part in the ordering.
  localparam int KEY_BITS = 16;

  // Port widths fixed by the interface.
  localparam int ROLL_W  = 16;
  localparam int GRADE_W = 8;
  localparam int IDX_W   = 5;

  // Stored key width: the port never carries more than ROLL_W bits.
  localparam int KEY_W = (KEY_BITS < ROLL_W) ? KEY_BITS : ROLL_W;
  // Record counter must hold CAPACITY itself.
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // One stored record.
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [GRADE_W-1:0] grade;
    logic [IDX_W-1:0]   idx;
  } rec_t;

  // Per-cycle control broadcast to every cell.
  typedef struct packed {
    logic ins;    // insert the broadcast record
    logic shift;  // move every record one cell toward the head
  } cell_ctl_t;

  // Sequencer states.
  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

endpackage

// ----- sv/rsort_cell.sv -----
// ----------------------------------------------------------------------------
// rsort_cell
// One slot of the sorting chain: holds a record and takes its neighbor's.
// ----------------------------------------------------------------------------
module rsort_cell import rsort_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  rec_t      new_rec_i,   // record being inserted (broadcast)
  input  rec_t      left_rec_i,  // record of the cell nearer the head
  input  logic      left_gt_i,   // that cell is moving its record up
  input  rec_t      right_rec_i, // record of the cell farther from the head
  output rec_t      rec_o,
  output logic      gt_o         // this cell lies above the insertion point
);

  logic               valid_q, valid_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [GRADE_W-1:0] grade_q, grade_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  rec_t               take;

  // An empty cell counts as an infinitely large key; equal keys stay put.
  assign gt_o = !valid_q || (key_q > new_rec_i.key);

  // Pick the record this cell takes over.
  always_comb begin
    take = '{valid: valid_q, key: key_q, grade: grade_q, idx: idx_q};
    if (ctl_i.shift) begin
      take = right_rec_i;
    end else if (ctl_i.ins && gt_o) begin
      take = left_gt_i ? left_rec_i : new_rec_i;
    end
  end

  assign valid_d = take.valid;
  assign key_d   = take.key;
  assign grade_d = take.grade;
  assign idx_d   = take.idx;

  // Occupancy flag is control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Record payload.
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    grade_q <= grade_d;
    idx_q   <= idx_d;
  end

  assign rec_o = '{valid: valid_q, key: key_q, grade: grade_q, idx: idx_q};

endmodule

// ----- sv/record_insertion_sort.sv -----
// ----------------------------------------------------------------------------
// record_insertion_sort
// Stable insertion sorter built as a chain of record cells.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake                | Payload
//   --------+--------------------------+------------------------------------
//   in      | in_valid_i / in_stall_o  | roll_number_i, grade_i, last_item_i
//   out     | out_valid_o / out_stall_i| sorted_key_o, sorted_grade_o,
//           |                          | arrival_index_o, is_last_o,
//           |                          | overflowed_o
//
// While loading, one request is taken every cycle; every cell compares its key
// with the incoming one in parallel and the record drops into place at once.
// After the request marked last, input stalls while the chain drains from its
// head: one result per cycle while the output does not stall. Output stalls
// hold the drain in place. Once the chain is empty it returns to loading.
// Reset empties the chain and clears the counter and the overflow flag.
// ----------------------------------------------------------------------------
module record_insertion_sort import rsort_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ROLL_W-1:0]  roll_number_i,
  input  logic [GRADE_W-1:0] grade_i,
  input  logic               last_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ROLL_W-1:0]  sorted_key_o,
  output logic [GRADE_W-1:0] sorted_grade_o,
  output logic [IDX_W-1:0]   arrival_index_o,
  output logic               is_last_o,
  output logic               overflowed_o
);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               ovf_q, ovf_d;
  logic               out_valid_q, out_valid_d;
  logic [KEY_W-1:0]   okey_q;
  logic [GRADE_W-1:0] ograde_q;
  logic [IDX_W-1:0]   oidx_q;
  logic               olast_q, oovf_q;

  logic      in_accept, full, out_take, out_load, batch_done;
  cell_ctl_t ctl;
  rec_t      new_rec;
  rec_t      recs [CAPACITY];
  logic      gts  [CAPACITY];

  // Handshake and chain status.
  assign in_accept  = in_valid_i && !in_stall_o;
  assign full       = recs[CAPACITY-1].valid;
  assign out_take   = out_valid_q && !out_stall_i;
  assign out_load   = (state_q == ST_DRAIN) && recs[0].valid && (!out_valid_q || out_take);
  assign batch_done = (state_q == ST_DRAIN) && !recs[0].valid;

  // Record presented to every cell.
  assign new_rec = '{valid: 1'b1,
                     key:   roll_number_i[KEY_W-1:0],
                     grade: grade_i,
                     idx:   count_q[IDX_W-1:0]};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_accept && last_item_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (batch_done) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall_o = 1'b1;
    case (state_q)
      ST_LOAD:  in_stall_o = 1'b0;
      ST_DRAIN: in_stall_o = 1'b1;
      default:  in_stall_o = 1'b1;
    endcase
  end

  // Cell control: insert while loading, shift toward the head while draining.
  assign ctl.ins   = in_accept && !full;
  assign ctl.shift = out_load;

  // Batch counter and overflow flag.
  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (batch_done) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (in_accept) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  assign out_valid_d = out_load ? 1'b1 : (out_take ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register takes the head of the chain.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      okey_q   <= recs[0].key;
      ograde_q <= recs[0].grade;
      oidx_q   <= recs[0].idx;
      olast_q  <= !recs[1].valid;
      oovf_q   <= ovf_q;
    end
  end

  // The chain of cells.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rec_t left_rec, right_rec;
    logic left_gt;

    if (i == 0) begin : g_head
      assign left_rec = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_rec = recs[i-1];
      assign left_gt  = gts[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_rec = '0;
    end else begin : g_body
      assign right_rec = recs[i+1];
    end

    rsort_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .new_rec_i   (new_rec),
      .left_rec_i  (left_rec),
      .left_gt_i   (left_gt),
      .right_rec_i (right_rec),
      .rec_o       (recs[i]),
      .gt_o        (gts[i])
    );
  end

  assign out_valid_o     = out_valid_q;
  assign sorted_key_o    = ROLL_W'(okey_q);
  assign sorted_grade_o  = ograde_q;
  assign arrival_index_o = oidx_q;
  assign is_last_o       = olast_q;
  assign overflowed_o    = oovf_q;

endmodule

// ----- sv/rsort_checker.sv -----
// ----------------------------------------------------------------------------
// rsort_checker
// Port-level checks on the sorter's request and result traffic.
// ----------------------------------------------------------------------------
module rsort_checker import rsort_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [ROLL_W-1:0]  roll_number_i,
  input logic [GRADE_W-1:0] grade_i,
  input logic               last_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [ROLL_W-1:0]  sorted_key_o,
  input logic [GRADE_W-1:0] sorted_grade_o,
  input logic [IDX_W-1:0]   arrival_index_o,
  input logic               is_last_o,
  input logic               overflowed_o
);

  // A stalled request holds.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(roll_number_i)
      && $stable(grade_i) && $stable(last_item_i))
    else $error("stalled request changed");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sorted_key_o)
      && $stable(sorted_grade_o) && $stable(arrival_index_o)
      && $stable(is_last_o) && $stable(overflowed_o))
    else $error("stalled result changed");

  // The request that closes a batch stalls the input for the drain.
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_item_i |=> in_stall_o)
    else $error("input not stalled after last request");

  // Inside a run the next result follows without a gap.
  a_run_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !is_last_o |=> out_valid_o)
    else $error("gap inside sorted run");

  // Results of one run rise in key and share the overflow flag.
  a_run_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !is_last_o |=>
      sorted_key_o >= $past(sorted_key_o) && overflowed_o == $past(overflowed_o))
    else $error("sorted run out of order");

endmodule

bind record_insertion_sort rsort_checker u_rsort_checker (.*);
